>>> rtl/tet_pkg.sv
package tet_pkg;

  localparam int unsigned IndexSpanDef = 1024;
  localparam int unsigned CountBitsDef = 11;

  localparam int unsigned OpW     = 2;
  localparam int unsigned IdxW    = 10;
  localparam int unsigned TileW   = 11;
  localparam int unsigned PosW    = 20;
  localparam int unsigned LenW    = 21;
  localparam int unsigned StatusW = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_SPAN   = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_TILE_W = 1'b0,
    REG_TILE_H = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    AX_IDLE, AX_CLEAR, AX_READ, AX_UPDATE, AX_SCAN_LO, AX_SCAN_HI
  } ax_state_e;

  typedef enum logic [2:0] {
    CORE_INIT, CORE_IDLE, CORE_WAIT, CORE_MUL, CORE_OUT
  } core_state_e;

  // command from the sequencer to both axis lanes
  typedef struct packed {
    logic start;
    logic clear;
    logic add;
  } lane_cmd_t;

  // lane report back to the sequencer
  typedef struct packed {
    logic done;
    logic changed;
    logic absent;
  } lane_rsp_t;

endpackage

>>> rtl/tet_ram.sv
module tet_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/tet_axis.sv
module tet_axis #(
  parameter int unsigned IndexSpan = 1024,
  parameter int unsigned CountBits = 11,
  localparam int unsigned SW = $clog2(IndexSpan)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tet_pkg::lane_cmd_t cmd_i,
  input  logic [SW-1:0]      slot_i,
  output tet_pkg::lane_rsp_t rsp_o,
  output logic               occupied_o,
  output logic [SW-1:0]      low_o,
  output logic [SW-1:0]      high_o
);
  import tet_pkg::*;

  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  ax_state_e            state_q, state_d;
  logic [SW:0]          occ_q, occ_d;
  logic [SW-1:0]        low_q, low_d, high_q, high_d;
  logic [SW-1:0]        slot_q, slot_d;
  logic [SW-1:0]        ptr_q, ptr_d;
  logic                 add_q, add_d;
  logic                 seek_hi_q, seek_hi_d;
  logic                 rd_valid_q, rd_valid_d;
  logic [SW-1:0]        rd_addr_q, rd_addr_d;
  logic                 we;
  logic [SW-1:0]        waddr, raddr;
  logic [CountBits-1:0] wdata, rdata;
  lane_rsp_t            rsp;

  tet_ram #(.Width(CountBits), .Depth(IndexSpan)) u_counts (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= AX_CLEAR;
      occ_q      <= '0;
      low_q      <= '0;
      high_q     <= '0;
      slot_q     <= '0;
      ptr_q      <= '0;
      add_q      <= 1'b0;
      seek_hi_q  <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      low_q      <= low_d;
      high_q     <= high_d;
      slot_q     <= slot_d;
      ptr_q      <= ptr_d;
      add_q      <= add_d;
      seek_hi_q  <= seek_hi_d;
      rd_valid_q <= rd_valid_d;
      rd_addr_q  <= rd_addr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    occ_d      = occ_q;
    low_d      = low_q;
    high_d     = high_q;
    slot_d     = slot_q;
    ptr_d      = ptr_q;
    add_d      = add_q;
    seek_hi_d  = seek_hi_q;
    rd_valid_d = 1'b0;
    we         = 1'b0;
    waddr      = slot_q;
    wdata      = '0;
    raddr      = slot_q;
    rsp        = '0;
    unique case (state_q)
      AX_IDLE: begin
        if (cmd_i.start) begin
          if (cmd_i.clear) begin
            rsp.changed = occ_q != '0;
            occ_d       = '0;
            low_d       = '0;
            high_d      = '0;
            ptr_d       = '0;
            state_d     = AX_CLEAR;
          end else begin
            slot_d  = slot_i;
            add_d   = cmd_i.add;
            raddr   = slot_i;
            state_d = AX_READ;
          end
        end
      end
      AX_CLEAR: begin
        we      = 1'b1;
        waddr   = ptr_q;
        ptr_d   = ptr_q + 1'b1;
        if (ptr_q == SW'(IndexSpan - 1)) begin
          rsp.done = 1'b1;
          state_d  = AX_IDLE;
        end
      end
      AX_READ: begin
        state_d = AX_UPDATE;
      end
      AX_UPDATE: begin
        state_d  = AX_IDLE;
        rsp.done = 1'b1;
        if (add_q) begin
          we = 1'b1;
          if (rdata == '0) begin
            wdata       = CountBits'(1);
            rsp.changed = 1'b1;
            occ_d       = occ_q + 1'b1;
            if (occ_q == '0) begin
              low_d  = slot_q;
              high_d = slot_q;
            end else begin
              if (slot_q < low_q) low_d = slot_q;
              if (slot_q > high_q) high_d = slot_q;
            end
          end else begin
            wdata = (rdata == CountMax) ? rdata : rdata + 1'b1;
          end
        end else if (rdata == '0) begin
          rsp.absent = 1'b1;
        end else begin
          we    = 1'b1;
          wdata = rdata - 1'b1;
          if (rdata == CountBits'(1)) begin
            rsp.changed = 1'b1;
            occ_d       = occ_q - 1'b1;
            if (occ_q == (SW+1)'(1)) begin
              low_d  = '0;
              high_d = '0;
            end else if (slot_q == low_q) begin
              seek_hi_d = slot_q == high_q;
              ptr_d     = slot_q + 1'b1;
              raddr     = slot_q + 1'b1;
              rd_valid_d = 1'b1;
              rsp.done  = 1'b0;
              state_d   = AX_SCAN_LO;
            end else if (slot_q == high_q) begin
              ptr_d     = slot_q - 1'b1;
              raddr     = slot_q - 1'b1;
              rd_valid_d = 1'b1;
              rsp.done  = 1'b0;
              state_d   = AX_SCAN_HI;
            end
          end
        end
      end
      AX_SCAN_LO: begin
        // occupancy > 0 guarantees a hit above the removed slot
        if (rd_valid_q && rdata != '0) begin
          low_d = rd_addr_q;
          if (seek_hi_q) begin
            high_d     = rd_addr_q;
            rsp.done   = 1'b1;
            state_d    = AX_IDLE;
          end else begin
            rsp.done = 1'b1;
            state_d  = AX_IDLE;
          end
        end else begin
          raddr      = ptr_q + 1'b1;
          ptr_d      = ptr_q + 1'b1;
          rd_valid_d = 1'b1;
        end
      end
      AX_SCAN_HI: begin
        if (rd_valid_q && rdata != '0) begin
          high_d   = rd_addr_q;
          rsp.done = 1'b1;
          state_d  = AX_IDLE;
        end else begin
          raddr      = ptr_q - 1'b1;
          ptr_d      = ptr_q - 1'b1;
          rd_valid_d = 1'b1;
        end
      end
      default: state_d = AX_IDLE;
    endcase
    rd_addr_d = raddr;
  end

  assign rsp_o      = rsp;
  assign occupied_o = occ_q != '0;
  assign low_o      = low_q;
  assign high_o     = high_q;

`ifndef SYNTH
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == AX_IDLE && occ_q != '0) |-> low_q <= high_q)
    else $error("low above high");
  a_single_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == AX_IDLE && occ_q == (SW+1)'(1)) |-> low_q == high_q)
    else $error("single index with distinct bounds");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == AX_IDLE && occ_q == '0) |-> (low_q == '0 && high_q == '0))
    else $error("empty axis bounds not zero");
`endif

endmodule

>>> rtl/tet_merge.sv
module tet_merge #(
  parameter int unsigned IndexSpan = 1024,
  localparam int unsigned SW = $clog2(IndexSpan)
) (
  input  logic                        clk_i,
  input  logic                        occupied_i,
  input  logic [SW-1:0]               low_i,
  input  logic [SW-1:0]               high_i,
  input  logic [tet_pkg::TileW-1:0]   size_i,
  output logic signed [tet_pkg::PosW-1:0] pos_o,
  output logic [tet_pkg::LenW-1:0]    len_o
);
  import tet_pkg::*;

  localparam int unsigned PW = SW + 2;
  localparam int unsigned MW = PW + TileW;

  logic signed [PW-1:0] off;
  logic [SW:0]          span;
  logic signed [MW-1:0] pos_q;
  logic [MW-1:0]        len_q;

  assign off  = $signed({2'b00, low_i}) - $signed(PW'(IndexSpan / 2));
  assign span = {1'b0, high_i} - {1'b0, low_i} + 1'b1;

  always_ff @(posedge clk_i) begin
    pos_q <= occupied_i ? MW'(off) * MW'($signed({1'b0, size_i})) : '0;
    len_q <= occupied_i ? MW'(span) * MW'(size_i) : '0;
  end

  always_comb begin
    if (pos_q < -$signed(MW'(1 << (PosW - 1)))) begin
      pos_o = {1'b1, {(PosW-1){1'b0}}};
    end else if (pos_q > $signed(MW'((1 << (PosW - 1)) - 1))) begin
      pos_o = {1'b0, {(PosW-1){1'b1}}};
    end else begin
      pos_o = pos_q[PosW-1:0];
    end
    if (len_q > MW'((1 << LenW) - 1)) begin
      len_o = '1;
    end else begin
      len_o = len_q[LenW-1:0];
    end
  end

endmodule

>>> rtl/tile_extent_tracker_core.sv
// An add or remove updates both axis lanes; a remove also scans for a new
// bound when the removed index was a bound; a clear sweeps the count memories.
// One word in flight at a time; the next word is taken the cycle after the
// result is taken. A scan of the count memory reads one address per cycle on
// each axis lane.
// Reset: asynchronous, active low; both count memories are swept to zero
// after reset, during which s_axis_tready is low.
module tile_extent_tracker_core #(
  parameter int unsigned INDEX_SPAN = tet_pkg::IndexSpanDef,
  parameter int unsigned COUNT_BITS = tet_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[1:0], col_index[11:2], row_index[21:12], zero fill
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // extent_x[19:0], extent_y[39:20], extent_width[60:40], extent_height[81:61],
  // status[83:82], zero fill
  output logic [87:0] m_axis_tdata,
  // extent_changed
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tet_pkg::*;

  localparam int unsigned SW = $clog2(INDEX_SPAN);

  core_state_e         state_q, state_d;
  logic [TileW-1:0]    tile_w_q, tile_h_q;
  logic                col_done_q, row_done_q, col_done_d, row_done_d;
  logic                changed_q, changed_d, absent_q, absent_d;
  status_e             status_q, status_d;
  lane_cmd_t           cmd;
  lane_rsp_t           col_rsp, row_rsp;
  logic                col_occ, row_occ;
  logic [SW-1:0]       col_lo, col_hi, row_lo, row_hi;
  logic [SW-1:0]       col_slot, row_slot;
  logic [IdxW:0]       col_ext, row_ext;
  logic                in_span;
  logic signed [PosW-1:0] ext_x, ext_y;
  logic [LenW-1:0]     ext_w, ext_h;
  logic                cfg_wr;
  op_e                 op;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q <= TileW'(64);
      tile_h_q <= TileW'(64);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TILE_W: tile_w_q <= pwdata[TileW-1:0];
        REG_TILE_H: tile_h_q <= pwdata[TileW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_TILE_W: prdata = 32'(tile_w_q);
      REG_TILE_H: prdata = 32'(tile_h_q);
      default: ;
    endcase
  end

  assign op      = op_e'(s_axis_tdata[1:0]);
  // sign-extended index plus half span, checked against the span
  assign col_ext = {s_axis_tdata[11], s_axis_tdata[11:2]} + (IdxW+1)'(INDEX_SPAN / 2);
  assign row_ext = {s_axis_tdata[21], s_axis_tdata[21:12]} + (IdxW+1)'(INDEX_SPAN / 2);
  always_comb begin
    in_span  = 1'b1;
    col_slot = '0;
    row_slot = '0;
    if (INDEX_SPAN >= (1 << IdxW)) begin
      col_slot = SW'($signed(s_axis_tdata[11:2]) + $signed((SW+1)'(INDEX_SPAN / 2)));
      row_slot = SW'($signed(s_axis_tdata[21:12]) + $signed((SW+1)'(INDEX_SPAN / 2)));
    end else begin
      in_span  = (col_ext < (IdxW+1)'(INDEX_SPAN)) && (row_ext < (IdxW+1)'(INDEX_SPAN));
      col_slot = SW'(col_ext);
      row_slot = SW'(row_ext);
    end
  end

  tet_axis #(.IndexSpan(INDEX_SPAN), .CountBits(COUNT_BITS)) u_col (
    .clk_i, .rst_ni, .cmd_i(cmd), .slot_i(col_slot), .rsp_o(col_rsp),
    .occupied_o(col_occ), .low_o(col_lo), .high_o(col_hi)
  );
  tet_axis #(.IndexSpan(INDEX_SPAN), .CountBits(COUNT_BITS)) u_row (
    .clk_i, .rst_ni, .cmd_i(cmd), .slot_i(row_slot), .rsp_o(row_rsp),
    .occupied_o(row_occ), .low_o(row_lo), .high_o(row_hi)
  );

  tet_merge #(.IndexSpan(INDEX_SPAN)) u_mx (
    .clk_i, .occupied_i(col_occ), .low_i(col_lo), .high_i(col_hi),
    .size_i(tile_w_q), .pos_o(ext_x), .len_o(ext_w)
  );
  tet_merge #(.IndexSpan(INDEX_SPAN)) u_my (
    .clk_i, .occupied_i(row_occ), .low_i(row_lo), .high_i(row_hi),
    .size_i(tile_h_q), .pos_o(ext_y), .len_o(ext_h)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= CORE_INIT;
      col_done_q <= 1'b0;
      row_done_q <= 1'b0;
      changed_q  <= 1'b0;
      absent_q   <= 1'b0;
      status_q   <= ST_OK;
    end else begin
      state_q    <= state_d;
      col_done_q <= col_done_d;
      row_done_q <= row_done_d;
      changed_q  <= changed_d;
      absent_q   <= absent_d;
      status_q   <= status_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    col_done_d    = col_done_q | col_rsp.done;
    row_done_d    = row_done_q | row_rsp.done;
    changed_d     = changed_q | col_rsp.changed | row_rsp.changed;
    absent_d      = absent_q | col_rsp.absent | row_rsp.absent;
    status_d      = status_q;
    cmd           = '0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      CORE_INIT: begin
        // wait for the reset sweep of both count memories
        if (col_done_d && row_done_d) begin
          state_d = CORE_IDLE;
        end
      end
      CORE_IDLE: begin
        s_axis_tready = 1'b1;
        col_done_d    = 1'b0;
        row_done_d    = 1'b0;
        changed_d     = 1'b0;
        absent_d      = 1'b0;
        status_d      = ST_OK;
        if (s_axis_tvalid) begin
          if (op == OP_CLEAR) begin
            cmd       = '{start: 1'b1, clear: 1'b1, add: 1'b0};
            changed_d = col_occ | row_occ;
            state_d   = CORE_WAIT;
          end else if (op == OP_NONE) begin
            state_d = CORE_MUL;
          end else if (!in_span) begin
            status_d = ST_SPAN;
            state_d  = CORE_MUL;
          end else begin
            cmd     = '{start: 1'b1, clear: 1'b0, add: op == OP_ADD};
            state_d = CORE_WAIT;
          end
        end
      end
      CORE_WAIT: begin
        if (col_done_d && row_done_d) begin
          state_d = CORE_MUL;
        end
      end
      CORE_MUL: begin
        if (absent_q) status_d = ST_ABSENT;
        state_d = CORE_OUT;
      end
      CORE_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          state_d    = CORE_IDLE;
          col_done_d = 1'b0;
          row_done_d = 1'b0;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  assign m_axis_tdata = {4'b0, status_q, ext_h, ext_w, ext_y, ext_x};
  assign m_axis_tuser = changed_q;

`ifndef SYNTH
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken with result pending");
  a_lanes_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CORE_OUT) |-> !(col_rsp.done || row_rsp.done))
    else $error("lane finished outside wait");
`endif

endmodule
